@@ hdl/lmpd_pkg.sv @@
package lmpd_pkg;

	localparam int MUL_W = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int F_W = 31;
	localparam int ROM_W = 30;
	localparam int Q_FRAC = 30;
	localparam int DECAY_FRAC = 10;
	localparam int SMOOTH_TERMS = 16;
	localparam int TERM_BITS = $clog2(SMOOTH_TERMS);

	localparam int DECAY_RATE_W = 20;
	localparam int HOLD_DUR_W = 16;
	localparam int REDRAW_W = 10;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_INDEX_W = 2;

	localparam logic [F_W-1:0] ONE_Q30 = F_W'(1) << Q_FRAC;
	localparam logic [PROD_W-1:0] HALF_Q30 = PROD_W'(1) << (Q_FRAC - 1);

	localparam logic [DECAY_RATE_W-1:0] DECAY_RATE_RST = DECAY_RATE_W'(16777);
	localparam logic [HOLD_DUR_W-1:0] HOLD_DUR_RST = HOLD_DUR_W'(2000);
	localparam logic [REDRAW_W-1:0] REDRAW_RST = REDRAW_W'(100);

	localparam logic [CFG_INDEX_W-1:0] REG_DECAY_RATE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_DURATION = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_REDRAW_INTERVAL = CFG_INDEX_W'(2);

	// 0.9^(2^k/256) in Q.30
	localparam logic [ROM_W-1:0] SMOOTH_ROM [SMOOTH_TERMS] = '{
		30'd1073300001, 30'd1072858360, 30'd1071975622, 30'd1070212325,
		30'd1066694429, 30'd1059693288, 30'd1045828559, 30'd1018640935,
		30'd966367642,  30'd869730877,  30'd704482011,  30'd462210647,
		30'd198966528,  30'd36868899,   30'd1265961,    30'd1493
	};

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_SMOOTH_MUL,
		ST_AVG_A,
		ST_AVG_B,
		ST_AVG_C,
		ST_TICK,
		ST_DECAY,
		ST_DECAY_SUB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] avg_in;
		logic [15:0] peak_in;
		logic [15:0] sample_count;
	} req_t;

	typedef struct packed {
		logic [15:0] avg_out;
		logic [15:0] peak_out;
		logic [15:0] decayed_peak_out;
		logic [15:0] hold_out;
	} res_t;

endpackage

@@ hdl/lmpd_mul.sv @@
module lmpd_mul
	import lmpd_pkg::*;
(
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

@@ hdl/level_meter_peak_decay_hold.sv @@
// A level update walks all smoothing terms, multiplying in one for each set bit of
// sample_count; a tick also evaluates the decay when the redraw interval completes.
// One request at a time: a new request is taken only once the previous result is
// registered, and all products go through the single shared 32x32 multiplier.
// arst_n clears all levels, ages and counters and loads register defaults.
module level_meter_peak_decay_hold
	import lmpd_pkg::*;
#(
	parameter int LEVEL_BITS = 16,
	parameter int AGE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  req_t                   req,
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_t                   res
);

	state_t state_q, state_d;

	logic [DECAY_RATE_W-1:0] decay_rate_q;
	logic [HOLD_DUR_W-1:0]   hold_dur_q;
	logic [REDRAW_W-1:0]     redraw_int_q;

	logic [LEVEL_BITS-1:0] avg_q, peak_q, decayed_q, hold_q;
	logic [AGE_BITS-1:0]   peak_age_q, hold_age_q;
	logic [REDRAW_W-1:0]   redraw_cnt_q;

	logic [LEVEL_BITS-1:0] a_in_q, p_in_q;
	logic [15:0]           count_q;
	logic [TERM_BITS-1:0]  term_q;
	logic [F_W-1:0]        f_q;
	logic [PROD_W-1:0]     acc_q;

	logic              res_valid_q;
	res_t              res_q;

	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod_s1;

	logic [F_W-1:0]        one_minus_f;
	logic [PROD_W-1:0]     f_round, avg_sum, peak_ext, decay_diff;
	logic [AGE_BITS-1:0]   peak_age_inc, hold_age_inc;
	logic [REDRAW_W-1:0]   redraw_inc, interval;
	logic                  redraw_due;
	logic                  term_set, term_last;

	assign one_minus_f  = ONE_Q30 - f_q;
	assign f_round      = prod_s1 + HALF_Q30;
	assign avg_sum      = acc_q + prod_s1 + HALF_Q30;
	assign peak_ext     = PROD_W'(peak_q) << DECAY_FRAC;
	assign decay_diff   = peak_ext - prod_s1;
	assign peak_age_inc = (peak_age_q == '1) ? peak_age_q : peak_age_q + 1'b1;
	assign hold_age_inc = (hold_age_q == '1) ? hold_age_q : hold_age_q + 1'b1;
	assign redraw_inc   = redraw_cnt_q + 1'b1;
	assign interval     = (redraw_int_q == '0) ? REDRAW_W'(1) : redraw_int_q;
	assign redraw_due   = (redraw_inc >= interval) || (redraw_inc == '0);
	assign term_set     = count_q[term_q];
	assign term_last    = (term_q == TERM_BITS'(SMOOTH_TERMS - 1));

	lmpd_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_rate_q <= DECAY_RATE_RST;
			hold_dur_q   <= HOLD_DUR_RST;
			redraw_int_q <= REDRAW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DECAY_RATE:      decay_rate_q <= cfg_data[DECAY_RATE_W-1:0];
				REG_HOLD_DURATION:   hold_dur_q   <= cfg_data[HOLD_DUR_W-1:0];
				REG_REDRAW_INTERVAL: redraw_int_q <= cfg_data[REDRAW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.command)
						CMD_UPDATE: state_d = ST_SMOOTH;
						CMD_TICK:   state_d = ST_TICK;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_SMOOTH: begin
				mul_a = MUL_W'(f_q);
				mul_b = MUL_W'(SMOOTH_ROM[term_q]);
				if (term_set) begin
					state_d = ST_SMOOTH_MUL;
				end else if (term_last) begin
					state_d = ST_AVG_A;
				end
			end
			ST_SMOOTH_MUL: begin
				state_d = term_last ? ST_AVG_A : ST_SMOOTH;
			end
			ST_AVG_A: begin
				mul_a   = MUL_W'(avg_q);
				mul_b   = MUL_W'(f_q);
				state_d = ST_AVG_B;
			end
			ST_AVG_B: begin
				mul_a   = MUL_W'(a_in_q);
				mul_b   = MUL_W'(one_minus_f);
				state_d = ST_AVG_C;
			end
			ST_AVG_C: begin
				state_d = ST_DONE;
			end
			ST_TICK: begin
				state_d = redraw_due ? ST_DECAY : ST_DONE;
			end
			ST_DECAY: begin
				mul_a   = MUL_W'(decay_rate_q);
				mul_b   = MUL_W'(peak_age_q);
				state_d = ST_DECAY_SUB;
			end
			ST_DECAY_SUB: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q        <= '0;
			peak_q       <= '0;
			decayed_q    <= '0;
			hold_q       <= '0;
			peak_age_q   <= '0;
			hold_age_q   <= '0;
			redraw_cnt_q <= '0;
			f_q          <= ONE_Q30;
			term_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						f_q    <= ONE_Q30;
						term_q <= '0;
						if (req.command == CMD_CLEAR) begin
							avg_q  <= '0;
							peak_q <= '0;
						end
					end
				end
				ST_SMOOTH: begin
					if (!term_set && !term_last) begin
						term_q <= term_q + 1'b1;
					end
				end
				ST_SMOOTH_MUL: begin
					f_q <= f_round[Q_FRAC +: F_W];
					if (!term_last) begin
						term_q <= term_q + 1'b1;
					end
				end
				ST_AVG_C: begin
					avg_q <= avg_sum[Q_FRAC +: LEVEL_BITS];
					// capture new peak and hold, restart their ages
					if (p_in_q > decayed_q) begin
						peak_q     <= p_in_q;
						decayed_q  <= p_in_q;
						peak_age_q <= '0;
					end
					if (p_in_q > hold_q) begin
						hold_q     <= p_in_q;
						hold_age_q <= '0;
					end
				end
				ST_TICK: begin
					peak_age_q   <= peak_age_inc;
					hold_age_q   <= hold_age_inc;
					redraw_cnt_q <= redraw_due ? '0 : redraw_inc;
				end
				ST_DECAY_SUB: begin
					decayed_q <= (prod_s1 < peak_ext) ?
						decay_diff[DECAY_FRAC +: LEVEL_BITS] : '0;
					if (MUL_W'(hold_age_q) > MUL_W'(hold_dur_q)) begin
						hold_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			a_in_q  <= LEVEL_BITS'(req.avg_in);
			p_in_q  <= LEVEL_BITS'(req.peak_in);
			count_q <= req.sample_count;
		end
		if (state_q == ST_AVG_B) begin
			acc_q <= prod_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!res_valid_q || res_ready)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!res_valid_q || res_ready)) begin
			res_q.avg_out          <= 16'(avg_q);
			res_q.peak_out         <= 16'(peak_q);
			res_q.decayed_peak_out <= 16'(decayed_q);
			res_q.hold_out         <= 16'(hold_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_factor_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		f_q <= ONE_Q30)
		else $error("smoothing factor above unity");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");

	a_request_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != ST_IDLE))
		else $error("accepted request left sequencer idle");

	a_redraw_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECAY) |-> (redraw_cnt_q == '0))
		else $error("decay evaluated without restarting redraw count");

endmodule

@@ dv/meter_checker.sv @@
module meter_checker
	import lmpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   req_valid,
	input  logic                   req_ready,
	input  req_t                   req,
	input  logic                   res_valid,
	input  logic                   res_ready,
	input  res_t                   res,
	output int                     readings_left,
	output int                     fails
);

	logic [DECAY_RATE_W-1:0] rate_q;
	logic [HOLD_DUR_W-1:0]   hold_dur_q;
	logic [REDRAW_W-1:0]     interval_q;

	logic [15:0]         avg_lvl;
	logic [15:0]         peak_lvl;
	logic [15:0]         decayed_lvl;
	logic [15:0]         hold_lvl;
	logic [15:0]         peak_age;
	logic [15:0]         hold_age;
	logic [REDRAW_W-1:0] redraw_cnt;

	res_t readings_q [$];

	function automatic string field_name(input int k);
		case (k)
			0: return "avg_out";
			1: return "peak_out";
			2: return "decayed_peak_out";
			default: return "hold_out";
		endcase
	endfunction

	function automatic logic [63:0] smooth_factor(input logic [15:0] count);
		logic [63:0] f;
		f = 64'd1 << Q_FRAC;
		for (int k = 0; k < SMOOTH_TERMS; k++)
			if (count[k])
				f = (f * SMOOTH_ROM[k] + HALF_Q30) >> Q_FRAC;
		return f;
	endfunction

	function automatic res_t advance_meter(input req_t r);
		logic [63:0]         f;
		logic [63:0]         acc;
		logic [63:0]         drop;
		logic [63:0]         scaled;
		logic [REDRAW_W-1:0] interval;
		res_t                o;
		case (r.command)
			CMD_UPDATE: begin
				f = smooth_factor(r.sample_count);
				acc = {48'd0, avg_lvl} * f + {48'd0, r.avg_in} * ((64'd1 << Q_FRAC) - f)
					+ HALF_Q30;
				avg_lvl = acc[Q_FRAC +: 16];
				if (r.peak_in > decayed_lvl) begin
					peak_lvl = r.peak_in;
					decayed_lvl = r.peak_in;
					peak_age = '0;
				end
				if (r.peak_in > hold_lvl) begin
					hold_lvl = r.peak_in;
					hold_age = '0;
				end
			end
			CMD_TICK: begin
				interval = (interval_q == '0) ? REDRAW_W'(1) : interval_q;
				if (peak_age != '1)
					peak_age = peak_age + 16'd1;
				if (hold_age != '1)
					hold_age = hold_age + 16'd1;
				redraw_cnt = redraw_cnt + 1'b1;
				if (redraw_cnt >= interval || redraw_cnt == '0) begin
					drop = {44'd0, rate_q} * {48'd0, peak_age};
					scaled = {48'd0, peak_lvl} << DECAY_FRAC;
					redraw_cnt = '0;
					acc = scaled - drop;
					decayed_lvl = (drop < scaled) ? acc[DECAY_FRAC +: 16] : 16'd0;
					if (hold_age > hold_dur_q)
						hold_lvl = '0;
				end
			end
			CMD_CLEAR: begin
				avg_lvl = '0;
				peak_lvl = '0;
			end
			default: begin
			end
		endcase
		o.avg_out = avg_lvl;
		o.peak_out = peak_lvl;
		o.decayed_peak_out = decayed_lvl;
		o.hold_out = hold_lvl;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			rate_q = DECAY_RATE_RST;
			hold_dur_q = HOLD_DUR_RST;
			interval_q = REDRAW_RST;
			avg_lvl = '0;
			peak_lvl = '0;
			decayed_lvl = '0;
			hold_lvl = '0;
			peak_age = '0;
			hold_age = '0;
			redraw_cnt = '0;
			readings_q.delete();
			fails = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (readings_q.size() == 0) begin
					fails++;
					$display("%0t: result with none expected, expected nothing, got %h",
						$time, res);
				end else begin
					want = readings_q.pop_front();
					for (int k = 0; k < 4; k++)
						if (want[63-16*k -: 16] !== res[63-16*k -: 16]) begin
							fails++;
							$display("%0t: %s expected %0d got %0d", $time, field_name(k),
								want[63-16*k -: 16], res[63-16*k -: 16]);
						end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DECAY_RATE: rate_q = cfg_data[DECAY_RATE_W-1:0];
					REG_HOLD_DURATION: hold_dur_q = cfg_data[HOLD_DUR_W-1:0];
					REG_REDRAW_INTERVAL: interval_q = cfg_data[REDRAW_W-1:0];
					default: begin
					end
				endcase
			end
			if (req_valid && req_ready)
				readings_q.push_back(advance_meter(req));
		end
		readings_left <= readings_q.size();
	end

endmodule

@@ dv/tb.sv @@
module tb;
	import lmpd_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int LIMIT = 4_000_000;
	localparam int HOLD_OFF_CYCLES = 300;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   req_valid;
	logic                   req_ready;
	req_t                   req;
	logic                   res_valid;
	logic                   res_ready;
	res_t                   res;

	int readings_left;
	int fails;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_reqs = 0;
	int cycle_count = 0;

	level_meter_peak_decay_hold DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	meter_checker meter_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.readings_left(readings_left),
		.fails(fails)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL level_meter_peak_decay_hold");
		$finish;
	end

	initial begin
		int stretch;
		int seen;
		stretch = 0;
		seen = 0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (seen != hold_off_reqs) begin
				seen = hold_off_reqs;
				stretch = HOLD_OFF_CYCLES;
			end
			if (stretch > 0) begin
				stretch--;
				res_ready = 1'b0;
			end else begin
				res_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic req_t meter_req(input logic [1:0] cmd, input logic [15:0] a,
		input logic [15:0] p, input logic [15:0] n);
		req_t r;
		r.command = cmd;
		r.avg_in = a;
		r.peak_in = p;
		r.sample_count = n;
		return r;
	endfunction

	function automatic req_t random_meter_req();
		req_t r;
		int pick;
		int shape;
		pick = $urandom_range(99);
		shape = $urandom_range(9);
		r.avg_in = 16'($urandom);
		r.peak_in = ($urandom_range(3) == 0) ? 16'($urandom_range(2000)) : 16'($urandom);
		case (shape)
			0: r.sample_count = 16'd0;
			1: r.sample_count = 16'hFFFF;
			2: r.sample_count = 16'd1 << $urandom_range(15);
			3, 4, 5: r.sample_count = 16'($urandom_range(1023));
			default: r.sample_count = 16'($urandom);
		endcase
		if (pick < 46)
			r.command = CMD_UPDATE;
		else if (pick < 92)
			r.command = CMD_TICK;
		else if (pick < 96)
			r.command = CMD_CLEAR;
		else
			r.command = CMD_UNUSED;
		return r;
	endfunction

	task automatic send_request(input req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		req_valid = 1'b0;
		while (readings_left != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_random_setting();
		logic [CFG_DATA_W-1:0] rate;
		logic [CFG_DATA_W-1:0] hold;
		logic [CFG_DATA_W-1:0] interval;
		case ($urandom_range(3))
			0: rate = '0;
			1: rate = 20'hFFFFF;
			2: rate = CFG_DATA_W'($urandom_range(20000));
			default: rate = CFG_DATA_W'($urandom);
		endcase
		case ($urandom_range(3))
			0: hold = '0;
			1: hold = 20'h0FFFF;
			2: hold = CFG_DATA_W'($urandom_range(60));
			default: hold = CFG_DATA_W'(16'($urandom));
		endcase
		case ($urandom_range(5))
			0: interval = '0;
			1: interval = 20'd1;
			2: interval = 20'd1023;
			default: interval = CFG_DATA_W'($urandom_range(1, 20));
		endcase
		write_reg(REG_DECAY_RATE, rate);
		write_reg(REG_HOLD_DURATION, hold);
		write_reg(REG_REDRAW_INTERVAL, interval);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(meter_req(CMD_UPDATE, 16'hFFFF, 16'hFFFF, 16'h0000));
		send_request(meter_req(CMD_UPDATE, 16'hFFFF, 16'h0000, 16'hFFFF));
		send_request(meter_req(CMD_UPDATE, 16'h0000, 16'd12345, 16'h0100));
		send_request(meter_req(CMD_TICK, 16'h5555, 16'hAAAA, 16'h8000));
		send_request(meter_req(CMD_UPDATE, 16'd16384, 16'hFFFF, 16'h0001));
		send_request(meter_req(CMD_UNUSED, 16'hA5A5, 16'h5A5A, 16'hFFFF));
		send_request(meter_req(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(meter_req(CMD_UPDATE, 16'd8000, 16'd100, 16'h1234));
		wait_quiet();

		// zero interval evaluates on every tick; zero hold clears at once
		write_reg(REG_DECAY_RATE, 20'hFFFFF);
		write_reg(REG_HOLD_DURATION, 20'd0);
		write_reg(REG_REDRAW_INTERVAL, 20'd0);
		send_request(meter_req(CMD_UPDATE, 16'd3000, 16'd40000, 16'h8001));
		send_request(meter_req(CMD_TICK, 16'd0, 16'd0, 16'd0));
		send_request(meter_req(CMD_TICK, 16'd0, 16'd0, 16'd0));
		send_request(meter_req(CMD_UPDATE, 16'd0, 16'hFFFF, 16'h0000));
		send_request(meter_req(CMD_TICK, 16'd0, 16'd0, 16'd0));
		send_request(meter_req(CMD_TICK, 16'd0, 16'd0, 16'd0));
		wait_quiet();

		// lower the interval below the running count
		write_reg(REG_DECAY_RATE, 20'd5000);
		write_reg(REG_REDRAW_INTERVAL, 20'd1023);
		send_request(meter_req(CMD_UPDATE, 16'd100, 16'd20000, 16'h00FF));
		repeat (4) send_request(meter_req(CMD_TICK, 16'd0, 16'd0, 16'd0));
		wait_quiet();
		write_reg(REG_REDRAW_INTERVAL, 20'd2);
		repeat (3) send_request(meter_req(CMD_TICK, 16'd0, 16'd0, 16'd0));
		wait_quiet();

		// age the peak and hold under a slow decay
		write_reg(REG_DECAY_RATE, 20'd1);
		write_reg(REG_HOLD_DURATION, 20'h0FFFF);
		write_reg(REG_REDRAW_INTERVAL, 20'd1023);
		send_request(meter_req(CMD_UPDATE, 16'd9000, 16'hFFFF, 16'h0003));
		repeat (20) send_request(meter_req(CMD_TICK, 16'($urandom), 16'($urandom),
			16'($urandom)));
		send_request(meter_req(CMD_UPDATE, 16'd1, 16'd10, 16'h0010));
		wait_quiet();
		write_reg(REG_REDRAW_INTERVAL, 20'd1);
		repeat (3) send_request(meter_req(CMD_TICK, 16'd0, 16'd0, 16'd0));
		wait_quiet();

		for (int seg = 0; seg < 8; seg++) begin
			case (seg % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 51;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 51;
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct = 36;
				end
			endcase
			write_random_setting();
			// hold off the receiver while requests keep coming
			if (seg == 1)
				hold_off_reqs++;
			repeat (100) send_request(random_meter_req());
			wait_quiet();
		end

		repeat (60) @(negedge clk);
		if (fails == 0)
			$display("PASS level_meter_peak_decay_hold");
		else
			$display("FAIL level_meter_peak_decay_hold");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/lmpd_pkg.sv
hdl/lmpd_mul.sv
hdl/level_meter_peak_decay_hold.sv
dv/meter_checker.sv
dv/tb.sv
